@@ hw/rtl/pip_pkg.sv @@
`default_nettype none

package pip_pkg;

  // Default capacity of the vertex ring.
  localparam int MAX_VERTICES_DEF = 64;

  // Fewest vertices that make a polygon with an inside.
  localparam int MIN_VERTICES = 3;

  localparam int COORD_W = 16;
  localparam int SW_W    = 15;

  // Coordinate differences, their products and the difference of two products.
  localparam int DIF_W = COORD_W + 1;
  localparam int PRD_W = 2 * DIF_W;
  localparam int ERR_W = PRD_W + 1;

  localparam logic [SW_W-1:0] SW_RESET = SW_W'(15360);

  // Request codes on the input channel.
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vtx_t;

  // Control shared by every cell of the ring.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic vld;
    logic clr;
  } edge_ctl_t;

  typedef struct packed {
    logic busy;
    logic right_odd;
    logic left_odd;
  } edge_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } st_t;

endpackage

`default_nettype wire

@@ hw/rtl/pip_cell.sv @@
`default_nettype none

// One vertex of the ring. It loads a new vertex when it is the next free slot,
// and during a walk it takes its right neighbour's vertex, or the head's when it
// is the last occupied slot, so that the ring rotates over the occupied cells.
module pip_cell import pip_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  wire logic             clk,
  input  wire cell_ctl_t        ctl,
  input  wire logic [CNT_W-1:0] count,
  input  wire vtx_t             load_v,
  input  wire vtx_t             next_v,
  input  wire vtx_t             head_v,
  output vtx_t                  v
);

  vtx_t v_r;
  vtx_t v_nxt;
  logic is_free;
  logic is_tail;

  assign is_free = (count == CNT_W'(IDX));
  assign is_tail = (count == CNT_W'(IDX + 1));

  always_comb begin
    v_nxt = v_r;
    if (ctl.load && is_free) begin
      v_nxt = load_v;
    end else if (ctl.shift) begin
      v_nxt = is_tail ? head_v : next_v;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  assign v = v_r;

endmodule

`default_nettype wire

@@ hw/rtl/pip_edge.sv @@
`default_nettype none

// Tests one polygon edge per cycle against both horizontal rays and keeps the
// parity of the hits. Three stages: differences, products, sign decisions.
module pip_edge import pip_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire edge_ctl_t                 ctl,
  input  wire vtx_t                      va,
  input  wire vtx_t                      vb,
  input  wire logic signed [COORD_W-1:0] qx,
  input  wire logic signed [COORD_W-1:0] qy,
  input  wire logic [SW_W-1:0]           sw,
  output edge_sts_t                      sts
);

  // Two values have the same strict sign: the point is outside their span.
  function automatic logic btw(input logic n1, input logic z1, input logic n2,
                               input logic z2);
    return !((n1 && n2) || (!n1 && !z1 && !n2 && !z2));
  endfunction

  function automatic logic opp(input logic n1, input logic z1, input logic n2,
                               input logic z2);
    return !z1 && !z2 && (n1 != n2);
  endfunction

  logic signed [DIF_W-1:0] qxe, qye, swe, x3, y3, x4, y4;

  // Stage one: differences.
  logic signed [DIF_W-1:0] dq3_nxt, dq4_nxt, ds3_nxt, ds4_nxt, d03_nxt, d04_nxt;
  logic signed [DIF_W-1:0] dy_nxt, tx_nxt, ty3_nxt, ty4_nxt;
  logic signed [DIF_W-1:0] dq3_r, dq4_r, ds3_r, ds4_r, d03_r, d04_r;
  logic signed [DIF_W-1:0] dy_r, tx_r, ty3_r, ty4_r;
  logic                    v1_r;

  // Stage two: products, with the differences the decisions still need.
  logic signed [PRD_W-1:0] pq_r, ps_r, p0_r, pt_r;
  logic signed [DIF_W-1:0] dq3_2r, dq4_2r, ds3_2r, ds4_2r, d03_2r, d04_2r;
  logic signed [DIF_W-1:0] ty3_2r, ty4_2r;
  logic                    v2_r;

  // Stage three: orientation values and hit decisions.
  logic signed [ERR_W-1:0] eq, es, e0;
  logic signed [DIF_W-1:0] dxr;
  logic                    ybox, t3z, t4z;
  logic                    hit_r, hit_l;
  logic                    right_r, left_r, right_nxt, left_nxt;

  assign qxe = DIF_W'(qx);
  assign qye = DIF_W'(qy);
  assign swe = signed'({2'b00, sw});
  assign x3  = DIF_W'(va.x);
  assign y3  = DIF_W'(va.y);
  assign x4  = DIF_W'(vb.x);
  assign y4  = DIF_W'(vb.y);

  always_comb begin
    dq3_nxt = qxe - x3;
    dq4_nxt = qxe - x4;
    ds3_nxt = swe - x3;
    ds4_nxt = swe - x4;
    d03_nxt = -x3;
    d04_nxt = -x4;
    dy_nxt  = y4 - y3;
    tx_nxt  = x4 - x3;
    ty3_nxt = qye - y3;
    ty4_nxt = qye - y4;
  end

  always_ff @(posedge clk) begin
    dq3_r  <= dq3_nxt;
    dq4_r  <= dq4_nxt;
    ds3_r  <= ds3_nxt;
    ds4_r  <= ds4_nxt;
    d03_r  <= d03_nxt;
    d04_r  <= d04_nxt;
    dy_r   <= dy_nxt;
    tx_r   <= tx_nxt;
    ty3_r  <= ty3_nxt;
    ty4_r  <= ty4_nxt;

    pq_r   <= dq3_r * dy_r;
    ps_r   <= ds3_r * dy_r;
    p0_r   <= d03_r * dy_r;
    pt_r   <= ty3_r * tx_r;
    dq3_2r <= dq3_r;
    dq4_2r <= dq4_r;
    ds3_2r <= ds3_r;
    ds4_2r <= ds4_r;
    d03_2r <= d03_r;
    d04_2r <= d04_r;
    ty3_2r <= ty3_r;
    ty4_2r <= ty4_r;
  end

  always_comb begin
    eq  = ERR_W'(pq_r) - ERR_W'(pt_r);
    es  = ERR_W'(ps_r) - ERR_W'(pt_r);
    e0  = ERR_W'(p0_r) - ERR_W'(pt_r);
    dxr = swe - qxe;
    t3z = (ty3_2r == '0);
    t4z = (ty4_2r == '0);
    ybox = btw(ty3_2r[DIF_W-1], t3z, ty4_2r[DIF_W-1], t4z);

    // Rightward ray: from the query point to the screen width.
    hit_r = (opp(eq[ERR_W-1], eq == '0, es[ERR_W-1], es == '0) && (dxr != '0) &&
             opp(ty3_2r[DIF_W-1], t3z, ty4_2r[DIF_W-1], t4z))
         || ((eq == '0) && ybox &&
             btw(dq3_2r[DIF_W-1], dq3_2r == '0, dq4_2r[DIF_W-1], dq4_2r == '0))
         || ((es == '0) && ybox &&
             btw(ds3_2r[DIF_W-1], ds3_2r == '0, ds4_2r[DIF_W-1], ds4_2r == '0))
         || (t3z && btw(dq3_2r[DIF_W-1], dq3_2r == '0, ds3_2r[DIF_W-1], ds3_2r == '0))
         || (t4z && btw(dq4_2r[DIF_W-1], dq4_2r == '0, ds4_2r[DIF_W-1], ds4_2r == '0));

    // Leftward ray: from x = 0 to the query point.
    hit_l = (opp(e0[ERR_W-1], e0 == '0, eq[ERR_W-1], eq == '0) && (qx != '0) &&
             opp(ty3_2r[DIF_W-1], t3z, ty4_2r[DIF_W-1], t4z))
         || ((e0 == '0) && ybox &&
             btw(d03_2r[DIF_W-1], d03_2r == '0, d04_2r[DIF_W-1], d04_2r == '0))
         || ((eq == '0) && ybox &&
             btw(dq3_2r[DIF_W-1], dq3_2r == '0, dq4_2r[DIF_W-1], dq4_2r == '0))
         || (t3z && btw(d03_2r[DIF_W-1], d03_2r == '0, dq3_2r[DIF_W-1], dq3_2r == '0))
         || (t4z && btw(d04_2r[DIF_W-1], d04_2r == '0, dq4_2r[DIF_W-1], dq4_2r == '0));

    right_nxt = right_r;
    left_nxt  = left_r;
    if (ctl.clr) begin
      right_nxt = 1'b0;
      left_nxt  = 1'b0;
    end else if (v2_r) begin
      right_nxt = right_r ^ hit_r;
      left_nxt  = left_r ^ hit_l;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      right_r <= 1'b0;
      left_r  <= 1'b0;
    end else begin
      v1_r    <= ctl.vld;
      v2_r    <= v1_r;
      right_r <= right_nxt;
      left_r  <= left_nxt;
    end
  end

  assign sts.busy      = v1_r | v2_r;
  assign sts.right_odd = right_r;
  assign sts.left_odd  = left_r;

endmodule

`default_nettype wire

@@ hw/rtl/point_in_polygon_crossing_test.sv @@
`default_nettype none

// Point-in-polygon crossing test. Vertices are added one beat at a time into a
// ring of MAX_VERTICES cells; a clear beat empties the ring and the overflow
// flag, and an add beat beyond capacity is dropped and sets that flag. A query
// beat casts two horizontal rays at the point's y, one from the point right to
// the configured screen width and one from x = 0 to the point, and counts the
// polygon edges, the closing edge included, that each ray meets; touching
// counts. The point is reported inside when both counts are odd, and always
// outside with fewer than three vertices. Coordinates are signed Q12.4 and all
// arithmetic is exact. During a query the ring rotates by one cell per cycle
// and feeds one edge per cycle into a single three-stage edge evaluator; a
// query with fewer than three vertices skips the walk. The result sits in an
// output register, so the next beat can be accepted while it waits to be
// taken. The screen width register is only to be written while no query is
// in flight.
module point_in_polygon_crossing_test import pip_pkg::*; #(
  parameter  int MAX_VERTICES = MAX_VERTICES_DEF,
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,

  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_req_type,
  input  wire logic signed [COORD_W-1:0] in_coord_x,
  input  wire logic signed [COORD_W-1:0] in_coord_y,

  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_inside_res,
  output logic [CNT_W-1:0]               out_vertex_count,
  output logic                           out_overflowed,

  input  wire logic                      cfg_wr_en,
  input  wire logic [SW_W-1:0]           cfg_wr_data
);

  st_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] walk_r, walk_nxt;
  logic             ovf_r, ovf_nxt;
  logic [SW_W-1:0]  sw_r;
  logic signed [COORD_W-1:0] qx_r, qy_r;

  logic             out_valid_r, out_valid_nxt;
  logic             out_inside_r;
  logic [CNT_W-1:0] out_count_r;
  logic             out_ovf_r;

  logic      in_acc;
  logic      full;
  logic      walk_last;
  logic      out_free;
  logic      out_load;
  logic      do_clear;
  logic      do_add;
  logic      do_query;
  cell_ctl_t cctl;
  edge_ctl_t ectl;
  edge_sts_t ests;
  vtx_t      in_vtx;
  vtx_t      ring [MAX_VERTICES];

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign full      = (count_r == CNT_W'(MAX_VERTICES));
  assign walk_last = (walk_r == count_r - CNT_W'(1));
  assign out_free  = !out_valid_r || !out_stall;
  assign in_vtx    = '{x: in_coord_x, y: in_coord_y};

  // Sequencer: decodes a beat in idle, rotates the ring once round for a query
  // of three or more vertices, then waits for the evaluator to drain and for
  // the output register to be free.
  always_comb begin
    state_nxt = state_r;
    do_clear  = 1'b0;
    do_add    = 1'b0;
    do_query  = 1'b0;
    out_load  = 1'b0;
    cctl      = '0;
    ectl      = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_req_type)
            REQ_CLEAR: do_clear = 1'b1;
            REQ_ADD:   do_add   = 1'b1;
            REQ_QUERY: begin
              do_query = 1'b1;
              ectl.clr = 1'b1;
              // Below three vertices the cleared parities already read as
              // outside, so the walk is skipped.
              state_nxt = (count_r >= CNT_W'(MIN_VERTICES)) ? ST_WALK : ST_DONE;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        cctl.shift = 1'b1;
        ectl.vld   = 1'b1;
        if (walk_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ests.busy && out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    cctl.load = do_add && !full;
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (do_clear) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (do_add) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
    walk_nxt = (state_r == ST_WALK) ? walk_r + CNT_W'(1) : '0;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      walk_r      <= '0;
      sw_r        <= SW_RESET;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        sw_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_query) begin
      qx_r <= in_coord_x;
      qy_r <= in_coord_y;
    end
    if (out_load) begin
      out_inside_r <= ests.right_odd && ests.left_odd;
      out_count_r  <= count_r;
      out_ovf_r    <= ovf_r;
    end
  end

  // The vertex ring. Cell 0 is the head; the edge under test is always the
  // pair held by cells 0 and 1, and one full rotation restores the order.
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_ring
    if (k == MAX_VERTICES - 1) begin : g_end
      pip_cell #(.IDX(k), .CNT_W(CNT_W)) u_cell (
        .clk    (clk),
        .ctl    (cctl),
        .count  (count_r),
        .load_v (in_vtx),
        .next_v (ring[0]),
        .head_v (ring[0]),
        .v      (ring[k])
      );
    end else begin : g_mid
      pip_cell #(.IDX(k), .CNT_W(CNT_W)) u_cell (
        .clk    (clk),
        .ctl    (cctl),
        .count  (count_r),
        .load_v (in_vtx),
        .next_v (ring[k+1]),
        .head_v (ring[0]),
        .v      (ring[k])
      );
    end
  end

  pip_edge u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ectl),
    .va    (ring[0]),
    .vb    (ring[1]),
    .qx    (qx_r),
    .qy    (qy_r),
    .sw    (sw_r),
    .sts   (ests)
  );

  assign out_valid        = out_valid_r;
  assign out_inside_res   = out_inside_r;
  assign out_vertex_count = out_count_r;
  assign out_overflowed   = out_ovf_r;

endmodule

`default_nettype wire

@@ hw/rtl/pip_checker.sv @@
`default_nettype none

module pip_checker import pip_pkg::*; #(
  parameter  int MAX_VERTICES = MAX_VERTICES_DEF,
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1)
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic [1:0]       in_req_type,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic             out_inside_res,
  input wire logic [CNT_W-1:0] out_vertex_count,
  input wire logic             out_overflowed
);

  // A stalled result beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inside_res) &&
      $stable(out_vertex_count) && $stable(out_overflowed))
    else $error("result beat changed while stalled");

  // Inside is only possible with a real polygon.
  a_inside_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_res |-> out_vertex_count >= CNT_W'(MIN_VERTICES))
    else $error("inside reported with fewer than three vertices");

  // A dropped vertex means the ring was full.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflowed |-> out_vertex_count == CNT_W'(MAX_VERTICES))
    else $error("overflow reported below capacity");

  // An accepted query holds the input side off in the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_req_type == REQ_QUERY |=> in_stall)
    else $error("input accepted straight after a query");

endmodule

bind point_in_polygon_crossing_test pip_checker #(.MAX_VERTICES(MAX_VERTICES)) u_pip_checker (.*);

`default_nettype wire
